// File: rtl/fas_pkg.sv
`timescale 1ns / 1ps

package fas_pkg;

  // Field widths of the single-precision word.
  localparam int FRAC_W = 23;
  localparam int EXP_W  = 8;
  localparam int MAN_W  = FRAC_W + 1;
  // Magnitude of a sum of two aligned mantissas needs one more bit.
  localparam int MAG_W  = MAN_W + 1;
  localparam int POS_W  = 5;
  // Exponent after normalisation, signed, wide enough for -23 .. 256.
  localparam int EADJ_W = EXP_W + 2;

  // Bit position that the leading one of a normalised mantissa occupies.
  localparam logic [POS_W-1:0] NORM_POS = POS_W'(FRAC_W);

  // Operation codes of the request.
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_SUB = 1'b1;

  // After alignment: both mantissas on the common exponent.
  typedef struct packed {
    logic              passthru;
    logic [31:0]       word;
    logic              sign_a;
    logic              sign_b;
    logic [MAN_W-1:0]  man_a;
    logic [MAN_W-1:0]  man_b;
    logic [EXP_W-1:0]  exp;
  } align_t;

  // After the signed addition: sign and magnitude of the sum.
  typedef struct packed {
    logic              passthru;
    logic [31:0]       word;
    logic              sign;
    logic [MAG_W-1:0]  mag;
    logic [EXP_W-1:0]  exp;
  } sum_t;

  // After leading-one detection.
  typedef struct packed {
    logic              passthru;
    logic [31:0]       word;
    logic              sign;
    logic [MAG_W-1:0]  mag;
    logic [EXP_W-1:0]  exp;
    logic [POS_W-1:0]  pos;
  } lead_t;

endpackage

// File: rtl/fas_align.sv
`timescale 1ns / 1ps

module fas_align (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic [31:0]      in_operand_a,
  input  logic [31:0]      in_operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output fas_pkg::align_t  out_data
);
  import fas_pkg::*;

  logic [31:0]      b_eff;
  logic [EXP_W-1:0] exp_a;
  logic [EXP_W-1:0] exp_b;
  logic [MAN_W-1:0] man_a;
  logic [MAN_W-1:0] man_b;
  align_t           data_nxt;
  align_t           data_r;
  logic             valid_r;

  // Unpack, detect zero operands and align the smaller mantissa.
  always_comb begin
    b_eff = in_operand_b ^ {(in_req_type == REQ_SUB), 31'b0};
    exp_a = in_operand_a[30:23];
    exp_b = b_eff[30:23];
    man_a = {1'b1, in_operand_a[FRAC_W-1:0]};
    man_b = {1'b1, b_eff[FRAC_W-1:0]};

    data_nxt.passthru = 1'b0;
    data_nxt.word     = '0;
    if (in_operand_a[30:0] == 31'd0) begin
      data_nxt.passthru = 1'b1;
      data_nxt.word     = b_eff;
    end else if (b_eff[30:0] == 31'd0) begin
      data_nxt.passthru = 1'b1;
      data_nxt.word     = in_operand_a;
    end

    data_nxt.sign_a = in_operand_a[31];
    data_nxt.sign_b = b_eff[31];
    if (exp_a > exp_b) begin
      data_nxt.man_a = man_a;
      data_nxt.man_b = man_b >> (exp_a - exp_b);
      data_nxt.exp   = exp_a;
    end else begin
      data_nxt.man_a = man_a >> (exp_b - exp_a);
      data_nxt.man_b = man_b;
      data_nxt.exp   = exp_b;
    end
  end

  // The stage takes a new request when empty or when its content moves on.
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // The operand with the larger exponent is never shifted.
  a_lead_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !data_r.passthru) |-> (data_r.man_a[MAN_W-1] || data_r.man_b[MAN_W-1]))
    else $error("aligned mantissas lost the leading one");

endmodule

// File: rtl/fas_addsub.sv
`timescale 1ns / 1ps

module fas_addsub (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fas_pkg::align_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fas_pkg::sum_t    out_data
);
  import fas_pkg::*;

  logic [MAG_W:0] val_a;
  logic [MAG_W:0] val_b;
  logic [MAG_W:0] sum;
  logic [MAG_W:0] mag_full;
  sum_t           data_nxt;
  sum_t           data_r;
  logic           valid_r;

  // Signed addition of the aligned mantissas, then sign and magnitude.
  always_comb begin
    val_a = {2'b00, in_data.man_a};
    val_b = {2'b00, in_data.man_b};
    if (in_data.sign_a) begin
      val_a = ~val_a + (MAG_W+1)'(1);
    end
    if (in_data.sign_b) begin
      val_b = ~val_b + (MAG_W+1)'(1);
    end
    sum      = val_a + val_b;
    mag_full = sum[MAG_W] ? (~sum + (MAG_W+1)'(1)) : sum;

    data_nxt.passthru = in_data.passthru;
    data_nxt.word     = in_data.word;
    data_nxt.sign     = sum[MAG_W];
    data_nxt.mag      = mag_full[MAG_W-1:0];
    data_nxt.exp      = in_data.exp;
    // A cancelled sum gives positive zero.
    if (!in_data.passthru && (sum == '0)) begin
      data_nxt.passthru = 1'b1;
      data_nxt.word     = '0;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Any request that is not passed through carries a non-zero magnitude.
  a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !data_r.passthru) |-> (data_r.mag != '0))
    else $error("zero magnitude reached normalisation");

endmodule

// File: rtl/fas_norm.sv
`timescale 1ns / 1ps

module fas_norm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fas_pkg::sum_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_sum_word,
  output logic             out_range_error
);
  import fas_pkg::*;

  lead_t              lead_nxt;
  lead_t              lead_r;
  logic               lead_valid_r;
  logic               lead_ready;
  logic               pack_ready;
  logic [POS_W-1:0]   lsh;
  logic [MAG_W-1:0]   shifted;
  logic [FRAC_W-1:0]  frac;
  logic [EADJ_W-1:0]  exp_adj;
  logic [31:0]        word_nxt;
  logic               err_nxt;
  logic [31:0]        word_r;
  logic               err_r;
  logic               pack_valid_r;

  // Leading-one detection: the highest set bit of the magnitude wins.
  always_comb begin
    lead_nxt.passthru = in_data.passthru;
    lead_nxt.word     = in_data.word;
    lead_nxt.sign     = in_data.sign;
    lead_nxt.mag      = in_data.mag;
    lead_nxt.exp      = in_data.exp;
    lead_nxt.pos      = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (in_data.mag[i]) begin
        lead_nxt.pos = POS_W'(i);
      end
    end
  end

  assign pack_ready = !pack_valid_r || out_ready;
  assign lead_ready = !lead_valid_r || pack_ready;
  assign in_ready   = lead_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_valid_r <= 1'b0;
    end else if (lead_ready) begin
      lead_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lead_ready && in_valid) begin
      lead_r <= lead_nxt;
    end
  end

  // Move the leading one to the hidden-bit position and pack the word.
  always_comb begin
    lsh     = NORM_POS - lead_r.pos;
    shifted = lead_r.mag << lsh;
    if (lead_r.pos > NORM_POS) begin
      frac = lead_r.mag[FRAC_W:1];
    end else begin
      frac = shifted[FRAC_W-1:0];
    end
    exp_adj = {2'b00, lead_r.exp} + {{(EADJ_W-POS_W){1'b0}}, lead_r.pos}
              - {{(EADJ_W-POS_W){1'b0}}, NORM_POS};
    if (lead_r.passthru) begin
      word_nxt = lead_r.word;
      err_nxt  = 1'b0;
    end else begin
      word_nxt = {lead_r.sign, exp_adj[EXP_W-1:0], frac};
      err_nxt  = (exp_adj[EADJ_W-1:EXP_W] != 2'b00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_valid_r <= 1'b0;
    end else if (pack_ready) begin
      pack_valid_r <= lead_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pack_ready && lead_valid_r) begin
      word_r <= word_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid       = pack_valid_r;
  assign out_sum_word    = word_r;
  assign out_range_error = err_r;

  // The detected position really is the leading one.
  a_lead_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (lead_valid_r && !lead_r.passthru) |-> ((lead_r.mag >> lead_r.pos) == MAG_W'(1)))
    else $error("leading-one position does not match the magnitude");

endmodule

// File: rtl/float32_add_sub_top.sv
`timescale 1ns / 1ps
// Single-precision add/subtract, four register stages: align, add, detect, pack.
// Throughput: one request per cycle while out_ready is high; each stage holds
// one request and moves it on whenever the next stage is free, so stalls
// ripple back without loss.
// Reset (synchronous, active low) clears the stage valid bits only.

module float32_add_sub_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sum_word,
  output logic        out_range_error
);
  import fas_pkg::*;

  align_t align_data;
  logic   align_valid;
  logic   align_ready;
  sum_t   sum_data;
  logic   sum_valid;
  logic   sum_ready;

  // Stage one: unpack and align.
  fas_align u_align (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (align_valid),
    .out_ready    (align_ready),
    .out_data     (align_data)
  );

  // Stage two: signed mantissa addition.
  fas_addsub u_addsub (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (align_valid),
    .in_ready  (align_ready),
    .in_data   (align_data),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_data  (sum_data)
  );

  // Stages three and four: leading-one detection, normalisation and packing.
  fas_norm u_norm (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sum_valid),
    .in_ready        (sum_ready),
    .in_data         (sum_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum_word    (out_sum_word),
    .out_range_error (out_range_error)
  );

endmodule

// File: verif/fp_sum_checker.sv
`timescale 1ns / 1ps

module fp_sum_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_sum_word,
  input  logic        out_range_error,
  output int          fail_count,
  output int          requests_seen,
  output int          results_seen,
  output int          range_flags_seen,
  output int          pending_count
);
  import fas_pkg::*;

  // One predicted result: the packed word and the exponent range flag.
  typedef struct packed {
    logic [31:0] word;
    logic        range_err;
  } fp_result_t;

  fp_result_t expected_sums[$];
  fp_result_t want;
  int         mismatch_total = 0;
  int         request_total = 0;
  int         result_total = 0;
  int         flag_total = 0;
  int         pending_total = 0;

  // Truncating single-precision add or subtract, with the implicit one
  // always set and an 8-bit wrap of the exponent when it leaves 0..255.
  function automatic fp_result_t predict_fp_sum(logic op, logic [31:0] a,
                                                logic [31:0] b_in);
    logic [31:0] b;
    logic [31:0] man_a;
    logic [31:0] man_b;
    logic [31:0] total;
    logic [31:0] mag;
    int          exp_a;
    int          exp_b;
    int          exp_r;
    int          diff;
    int          lead;
    fp_result_t  r;
    r = '0;
    b = b_in;
    if (op == REQ_SUB) begin
      b[31] = ~b[31];
    end
    // A zero operand passes the other one through unchanged.
    if (a[30:0] == 31'd0) begin
      r.word = b;
      return r;
    end
    if (b[30:0] == 31'd0) begin
      r.word = a;
      return r;
    end
    exp_a = int'(a[30:23]);
    exp_b = int'(b[30:23]);
    man_a = {8'd0, 1'b1, a[22:0]};
    man_b = {8'd0, 1'b1, b[22:0]};
    // Align the smaller operand onto the larger exponent.
    if (exp_a > exp_b) begin
      diff  = exp_a - exp_b;
      man_b = (diff >= 32) ? 32'd0 : (man_b >> diff);
      exp_r = exp_a;
    end else begin
      diff  = exp_b - exp_a;
      man_a = (diff >= 32) ? 32'd0 : (man_a >> diff);
      exp_r = exp_b;
    end
    // Two's complement addition in 32 bits.
    if (a[31]) begin
      man_a = -man_a;
    end
    if (b[31]) begin
      man_b = -man_b;
    end
    total = man_a + man_b;
    if (total == 32'd0) begin
      return r;
    end
    mag = total[31] ? -total : total;
    // Normalise the leading one onto bit 23, truncating on a right shift.
    lead = 31;
    while (lead > 0 && !mag[lead]) begin
      lead--;
    end
    if (lead > 23) begin
      mag   = mag >> (lead - 23);
      exp_r = exp_r + (lead - 23);
    end else if (lead < 23) begin
      mag   = mag << (23 - lead);
      exp_r = exp_r - (23 - lead);
    end
    r.word      = {total[31], exp_r[7:0], mag[22:0]};
    r.range_err = (exp_r < 0) || (exp_r > 255);
    return r;
  endfunction

  // Queue a prediction for every accepted request and compare every result.
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_sums.delete();
      pending_total = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_sums.push_back(predict_fp_sum(in_req_type, in_operand_a, in_operand_b));
        request_total++;
      end
      if (out_valid && out_ready) begin
        result_total++;
        if (out_range_error) begin
          flag_total++;
        end
        if (expected_sums.size() == 0) begin
          if (mismatch_total < 10) begin
            $display("%0t: result %h/%b arrived with no request outstanding",
                     $time, out_sum_word, out_range_error);
          end
          mismatch_total++;
        end else begin
          want = expected_sums.pop_front();
          if (out_sum_word !== want.word || out_range_error !== want.range_err) begin
            if (mismatch_total < 10) begin
              $display("%0t: mismatch sum_word exp %h got %h, range_error exp %b got %b",
                       $time, want.word, out_sum_word, want.range_err, out_range_error);
            end
            mismatch_total++;
          end
        end
      end
      pending_total = expected_sums.size();
    end
  end

  assign fail_count       = mismatch_total;
  assign requests_seen    = request_total;
  assign results_seen     = result_total;
  assign range_flags_seen = flag_total;
  assign pending_count    = pending_total;

endmodule

// File: verif/float32_add_sub_top_test.sv
`timescale 1ns / 1ps

module float32_add_sub_top_test;
  import fas_pkg::*;

  // Shapes of random operand pairs.
  typedef enum int {
    MIX_ANY,
    MIX_NEAR_EXP,
    MIX_CANCEL,
    MIX_ZERO,
    MIX_EXTREME_EXP,
    MIX_LOW_EXP,
    MIX_HIGH_EXP
  } pair_mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = REQ_ADD;
  logic [31:0] in_operand_a = 32'd0;
  logic [31:0] in_operand_b = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_sum_word;
  logic        out_range_error;

  int fail_count;
  int requests_seen;
  int results_seen;
  int range_flags_seen;
  int pending_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  float32_add_sub_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sum_word    (out_sum_word),
    .out_range_error (out_range_error)
  );

  fp_sum_checker sum_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sum_word     (out_sum_word),
    .out_range_error  (out_range_error),
    .fail_count       (fail_count),
    .requests_seen    (requests_seen),
    .results_seen     (results_seen),
    .range_flags_seen (range_flags_seen),
    .pending_count    (pending_count)
  );

  always #6 clk = ~clk;

  // Result side: random back-pressure, or a long hold-off when one is asked for.
  always @(negedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request and return at the falling edge after it was taken.
  task automatic offer_request(input logic op, input logic [31:0] a,
                               input logic [31:0] b);
    int taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    taken = requests_seen;
    do begin
      @(negedge clk);
    end while (requests_seen == taken);
  endtask

  // Stop sending and wait until every outstanding request has been answered.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) begin
      @(negedge clk);
    end
  endtask

  // Ask the result side for a long stall while requests keep coming.
  task automatic request_hold_off();
    in_valid <= 1'b0;
    @(posedge clk);
    holds_asked++;
    @(negedge clk);
  endtask

  // Draw one random operand pair, biased towards the interesting corners.
  task automatic random_request();
    pair_mix_t   mix;
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
    int          pick;
    pick = $urandom_range(99);
    op   = 1'($urandom_range(1));
    a    = $urandom();
    b    = $urandom();
    if (pick < 25)      mix = MIX_ANY;
    else if (pick < 45) mix = MIX_NEAR_EXP;
    else if (pick < 60) mix = MIX_CANCEL;
    else if (pick < 68) mix = MIX_ZERO;
    else if (pick < 78) mix = MIX_EXTREME_EXP;
    else if (pick < 89) mix = MIX_LOW_EXP;
    else                mix = MIX_HIGH_EXP;
    case (mix)
      MIX_NEAR_EXP: begin
        b[30:23] = a[30:23] ^ 8'($urandom_range(3));
      end
      MIX_CANCEL: begin
        // Nearly or exactly equal magnitudes, so the sum can cancel heavily.
        b = a ^ 32'($urandom_range(255) & ($urandom_range(1) ? 255 : 0));
        b[31] = 1'($urandom_range(1));
      end
      MIX_ZERO: begin
        if ($urandom_range(1)) a[30:0] = 31'd0;
        if ($urandom_range(1)) b[30:0] = 31'd0;
      end
      MIX_EXTREME_EXP: begin
        a[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
        b[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      MIX_LOW_EXP: begin
        a[30:23] = 8'($urandom_range(3));
        b[30:23] = 8'($urandom_range(3));
        b[22:8]  = a[22:8];
      end
      MIX_HIGH_EXP: begin
        a[30:23] = 8'($urandom_range(255, 250));
        b[30:23] = 8'($urandom_range(255, 250));
        b[31]    = a[31] ^ op;
      end
      default: begin
      end
    endcase
    offer_request(op, a, b);
  endtask

  // One stretch of random requests under a given idling mix.
  task automatic run_phase(input int send_pct, input int recv_pct,
                           input int count, input bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 4) begin
        request_hold_off();
      end
      random_request();
    end
    drain_results();
  endtask

  // Directed corners first, then three random phases.
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero operands, with and without subtraction.
    offer_request(REQ_ADD, 32'h0000_0000, 32'h0000_0000);
    offer_request(REQ_SUB, 32'h0000_0000, 32'h8000_0000);
    offer_request(REQ_ADD, 32'h8000_0000, 32'h3FC0_0000);
    offer_request(REQ_SUB, 32'h0000_0000, 32'h3FC0_0000);
    offer_request(REQ_ADD, 32'h4049_0FDB, 32'h8000_0000);
    offer_request(REQ_SUB, 32'h8000_0001, 32'h0000_0000);
    // Sums that cancel to zero.
    offer_request(REQ_ADD, 32'h3F80_0000, 32'hBF80_0000);
    offer_request(REQ_SUB, 32'hC000_0000, 32'hC000_0000);
    // Carry into a higher exponent, and exponent overflow.
    offer_request(REQ_ADD, 32'h3F80_0000, 32'h3F80_0000);
    offer_request(REQ_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    offer_request(REQ_ADD, 32'h7F80_0000, 32'h7F80_0000);
    offer_request(REQ_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    // Heavy cancellation: exponent underflow near exponent zero, then across neighbouring exponents.
    offer_request(REQ_SUB, 32'h0000_0001, 32'h0000_0002);
    offer_request(REQ_SUB, 32'h3F80_0000, 32'h3F7F_FFFF);
    // Zero exponents still carry the implicit one.
    offer_request(REQ_ADD, 32'h0040_0000, 32'h0020_0000);
    // Alignment shifts of 31, 32 and the largest difference.
    offer_request(REQ_ADD, 32'h4F00_0000, 32'h3F80_0000);
    offer_request(REQ_ADD, 32'h4F80_0000, 32'h3F80_0000);
    offer_request(REQ_ADD, 32'h7F80_0000, 32'h0000_0001);
    // Mixed signs and all-ones patterns.
    offer_request(REQ_ADD, 32'hBF80_0000, 32'h4000_0000);
    offer_request(REQ_ADD, 32'hC040_0000, 32'h3F80_0000);
    offer_request(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(REQ_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
    offer_request(REQ_SUB, 32'hAAAA_AAAA, 32'h5555_5555);
    drain_results();

    run_phase(17, 50, 430, 1'b1);
    run_phase(50, 17, 430, 1'b0);
    run_phase(0, 0, 430, 1'b1);

    repeat (24) @(negedge clk);
    $display("Summary: %0d requests and %0d results checked, %0d with the range flag set,",
             requests_seen, results_seen, range_flags_seen);
    $display("covering corner operands, three idling mixes, output hold-offs and drains.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still outstanding.", pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/fas_pkg.sv
rtl/fas_align.sv
rtl/fas_addsub.sv
rtl/fas_norm.sv
rtl/float32_add_sub_top.sv
verif/fp_sum_checker.sv
verif/float32_add_sub_top_test.sv
